FILE: sv/dllc_pkg.sv
package dllc_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_FIRST  = 3'd1,
    CMD_NEXT   = 3'd2,
    CMD_PREV   = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_END   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_NOCUR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_NODE   = 2'd1,
    MODE_BEFORE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_LINK  = 2'd1,
    S_VALUE = 2'd2,
    S_FIX   = 2'd3
  } state_e;

endpackage

FILE: sv/dllc_ram.sv
module dllc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/doubly_linked_list_cursor_engine.sv
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             command_i, value_i
// result    out        done_o (one-cycle strobe) status_o, value_out_o, element_count_o
//
// A command runs through S_LINK, then S_VALUE or S_FIX if needed, before the
// done_o strobe; busy is low again in the strobe cycle, so the next command can
// be taken there. S_LINK only: go first, go next from before-first, append to
// an empty list, remove of the first node, and every failing or unused command.
// Then S_VALUE or S_FIX: a move that follows a link (the link comes out of the
// registered RAM read before the node it names can be read), and append or remove
// that must patch a second next-link entry through the single next-link write port.
// Reset is asynchronous, active low; the link and value RAMs are not cleared.
// The receiver cannot stall: done_o marks each result for one cycle only.
module doubly_linked_list_cursor_engine #(
  parameter int POOL_DEPTH = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          command_i,
  input  logic signed [DATA_WIDTH-1:0]        value_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic signed [DATA_WIDTH-1:0]        value_out_o,
  output logic [$clog2(POOL_DEPTH+1)-1:0]     element_count_o
);

  import dllc_pkg::*;

  localparam int IW = $clog2(POOL_DEPTH);      // pool index
  localparam int LW = $clog2(POOL_DEPTH + 1);  // link, index or null
  localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

  function automatic logic is_node(input logic [LW-1:0] x);
    return x < NIL;
  endfunction

  // list control state
  state_e          state_q, state_d;
  logic [LW-1:0]   first_q, first_d;
  logic [LW-1:0]   last_q, last_d;
  logic [LW-1:0]   cur_q, cur_d;
  mode_e           mode_q, mode_d;
  logic [LW-1:0]   count_q, count_d;
  logic [LW-1:0]   fresh_q, fresh_d;   // entries from here up never used
  logic [LW-1:0]   free_q, free_d;     // free list head, chained by next link
  logic            done_q, done_d;

  // per-command working registers
  cmd_e            cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [LW-1:0]   node_q, node_d;     // target node of a link move
  logic [IW-1:0]   fix_addr_q, fix_addr_d;
  logic [LW-1:0]   fix_data_q, fix_data_d;
  status_e         res_status_q, res_status_d;
  logic [DATA_WIDTH-1:0] res_value_q, res_value_d;

  // RAM ports: all three share one read address
  logic [IW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_val;
  logic [LW-1:0]         rd_next, rd_prev;
  logic                  val_we, nxt_we, prv_we;
  logic [IW-1:0]         val_waddr, nxt_waddr, prv_waddr;
  logic [DATA_WIDTH-1:0] val_wdata;
  logic [LW-1:0]         nxt_wdata, prv_wdata;

  // decisions shared by the next-state and datapath blocks
  logic          cur_ok, pool_full, want_value, want_fix;
  logic [LW-1:0] sel_link, alloc;

  assign cur_ok    = (mode_q == MODE_NODE) && is_node(cur_q);
  assign pool_full = !is_node(free_q) && (fresh_q == NIL);
  assign alloc     = is_node(free_q) ? free_q : fresh_q;

  // S_VALUE needs a value read at the node the link pointed to
  assign want_value = ((cmd_q == CMD_NEXT) && (mode_q != MODE_BEFORE) && cur_ok
                       && is_node(rd_next))
                   || ((cmd_q == CMD_PREV) && cur_ok && is_node(rd_prev));
  // a second next-link write is pending
  assign want_fix = ((cmd_q == CMD_APPEND) && !pool_full && is_node(last_q))
                 || ((cmd_q == CMD_REMOVE) && cur_ok && is_node(rd_prev));

  // read address at command transfer
  always_comb begin
    case (cmd_e'(command_i))
      CMD_APPEND: sel_link = free_q;
      CMD_FIRST:  sel_link = first_q;
      CMD_NEXT:   sel_link = (mode_q == MODE_BEFORE) ? first_q : cur_q;
      default:    sel_link = cur_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_LINK;
      end
      S_LINK: begin
        if (want_value)    state_d = S_VALUE;
        else if (want_fix) state_d = S_FIX;
        else               state_d = S_IDLE;
      end
      S_VALUE: state_d = S_IDLE;
      S_FIX:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    first_d      = first_q;
    last_d       = last_q;
    cur_d        = cur_q;
    mode_d       = mode_q;
    count_d      = count_q;
    fresh_d      = fresh_q;
    free_d       = free_q;
    cmd_d        = cmd_q;
    val_d        = val_q;
    node_d       = node_q;
    fix_addr_d   = fix_addr_q;
    fix_data_d   = fix_data_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    rd_addr      = node_q[IW-1:0];
    val_we       = 1'b0;
    val_waddr    = alloc[IW-1:0];
    val_wdata    = val_q;
    nxt_we       = 1'b0;
    nxt_waddr    = fix_addr_q;
    nxt_wdata    = fix_data_q;
    prv_we       = 1'b0;
    prv_waddr    = rd_next[IW-1:0];
    prv_wdata    = rd_prev;

    case (state_q)
      S_IDLE: begin
        rd_addr = sel_link[IW-1:0];
        if (start) begin
          cmd_d = cmd_e'(command_i);
          val_d = value_i;
        end
      end

      S_LINK: begin
        res_status_d = STAT_OK;
        res_value_d  = '0;
        case (cmd_q)
          CMD_APPEND: begin
            if (pool_full) begin
              res_status_d = STAT_FULL;
            end else begin
              if (is_node(free_q)) free_d = rd_next;
              else                 fresh_d = fresh_q + 1'b1;
              val_we    = 1'b1;
              nxt_we    = 1'b1;
              nxt_waddr = alloc[IW-1:0];
              nxt_wdata = NIL;
              prv_we    = 1'b1;
              prv_waddr = alloc[IW-1:0];
              prv_wdata = last_q;
              if (is_node(last_q)) begin
                fix_addr_d = last_q[IW-1:0];
                fix_data_d = alloc;
              end else begin
                first_d = alloc;
              end
              last_d  = alloc;
              count_d = count_q + 1'b1;
            end
          end
          CMD_FIRST: begin
            if (!is_node(first_q)) begin
              res_status_d = STAT_END;
            end else begin
              cur_d       = first_q;
              mode_d      = MODE_NODE;
              res_value_d = rd_val;
            end
          end
          CMD_NEXT: begin
            if (mode_q == MODE_BEFORE) begin
              if (!is_node(first_q)) begin
                res_status_d = STAT_END;
              end else begin
                cur_d       = first_q;
                mode_d      = MODE_NODE;
                res_value_d = rd_val;
              end
            end else if (want_value) begin
              node_d  = rd_next;
              rd_addr = rd_next[IW-1:0];
            end else begin
              res_status_d = STAT_END;
            end
          end
          CMD_PREV: begin
            if (want_value) begin
              node_d  = rd_prev;
              rd_addr = rd_prev[IW-1:0];
            end else begin
              res_status_d = STAT_END;
            end
          end
          CMD_REMOVE: begin
            if (!cur_ok) begin
              res_status_d = STAT_NOCUR;
            end else begin
              res_value_d = rd_val;
              // neighbor after the removed node points back past it
              if (is_node(rd_next)) prv_we = 1'b1;
              else                  last_d = rd_prev;
              // removed node goes on the free list
              nxt_we    = 1'b1;
              nxt_waddr = cur_q[IW-1:0];
              nxt_wdata = free_q;
              free_d    = cur_q;
              if (is_node(rd_prev)) begin
                fix_addr_d = rd_prev[IW-1:0];
                fix_data_d = rd_next;
                cur_d      = rd_prev;
                mode_d     = MODE_NODE;
              end else begin
                first_d = rd_next;
                cur_d   = NIL;
                mode_d  = MODE_BEFORE;
              end
              if (count_q != '0) count_d = count_q - 1'b1;
            end
          end
          default: begin
            // unused codes: ok, zero, no change
          end
        endcase
      end

      S_VALUE: begin
        cur_d       = node_q;
        mode_d      = MODE_NODE;
        res_value_d = rd_val;
      end

      S_FIX: begin
        nxt_we = 1'b1;
      end

      default: begin
      end
    endcase
  end

  assign done_d = (state_q != S_IDLE) && (state_d == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= NIL;
      last_q  <= NIL;
      cur_q   <= NIL;
      mode_q  <= MODE_NONE;
      count_q <= '0;
      fresh_q <= '0;
      free_q  <= NIL;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      last_q  <= last_d;
      cur_q   <= cur_d;
      mode_q  <= mode_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
      free_q  <= free_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    val_q        <= val_d;
    node_q       <= node_d;
    fix_addr_q   <= fix_addr_d;
    fix_data_q   <= fix_data_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
  end

  dllc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_val)
  );

  dllc_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_next)
  );

  dllc_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_prev)
  );

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = res_status_q;
  assign value_out_o     = res_value_q;
  assign element_count_o = count_q;

endmodule

FILE: sv/dllc_checker.sv
module dllc_props #(
  parameter int POOL_DEPTH = 256,
  parameter int DATA_WIDTH = 32
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic [1:0]                      status_o,
  input logic [DATA_WIDTH-1:0]           value_out_o,
  input logic [$clog2(POOL_DEPTH+1)-1:0] element_count_o
);

  import dllc_pkg::*;

  localparam int LW = $clog2(POOL_DEPTH + 1);

  // a transfer always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");

  // a result only closes a command in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result strobe without a command in progress");

  // count moves only under a command
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> $stable(element_count_o))
    else $error("element count changed while idle");

  // failed commands return zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STAT_OK)) |-> (value_out_o == '0))
    else $error("nonzero value with a failing status");

  // full means every pool entry is in the list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_FULL)) |-> (element_count_o == LW'(POOL_DEPTH)))
    else $error("pool full reported with free entries");

endmodule

bind doubly_linked_list_cursor_engine dllc_props #(
  .POOL_DEPTH(POOL_DEPTH),
  .DATA_WIDTH(DATA_WIDTH)
) u_dllc_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .value_out_o     (value_out_o),
  .element_count_o (element_count_o)
);

FILE: tb/sv/dllc_checker.sv
// Watches both channels of the list engine, predicts each result and compares.
module dllc_checker #(
  parameter int POOL_DEPTH = 256,
  parameter int DATA_WIDTH = 32,
  localparam int CW = $clog2(POOL_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [2:0]                   command_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         done_o,
  input  logic [1:0]                   status_o,
  input  logic signed [DATA_WIDTH-1:0] value_out_o,
  input  logic [CW-1:0]                element_count_o,
  output int                           fail_count_o,
  output int                           outstanding_o
);

  import dllc_pkg::*;

  localparam logic [CW-1:0] NIL = CW'(POOL_DEPTH);

  typedef struct {
    status_e                  status;
    logic signed [DATA_WIDTH-1:0] value;
    logic [CW-1:0]            count;
  } list_result_t;

  // shadow of the node pool and list registers
  logic signed [DATA_WIDTH-1:0] node_val [POOL_DEPTH];
  logic [CW-1:0]                fwd_link [POOL_DEPTH];
  logic [CW-1:0]                back_link[POOL_DEPTH];
  logic [CW-1:0]                head_idx, tail_idx, cur_idx, fresh_idx, free_idx, elem_count;
  mode_e                        cur_mode;

  list_result_t result_q[$];
  int           errors = 0;

  function automatic list_result_t apply_command(logic [2:0] cmd,
                                                 logic signed [DATA_WIDTH-1:0] val);
    list_result_t r;
    logic [CW-1:0] n, p, q;
    r.status = STAT_OK;
    r.value  = '0;
    n        = NIL;
    case (cmd)
      CMD_APPEND: begin
        if (free_idx != NIL) begin
          n        = free_idx;
          free_idx = fwd_link[n];
        end else if (fresh_idx < NIL) begin
          n         = fresh_idx;
          fresh_idx = fresh_idx + 1'b1;
        end else begin
          r.status = STAT_FULL;
        end
        if (n != NIL) begin
          node_val[n]  = val;
          fwd_link[n]  = NIL;
          back_link[n] = tail_idx;
          if (tail_idx != NIL) fwd_link[tail_idx] = n;
          else head_idx = n;
          tail_idx   = n;
          elem_count = elem_count + 1'b1;
        end
      end
      CMD_FIRST: begin
        if (head_idx == NIL) begin
          r.status = STAT_END;
        end else begin
          cur_idx  = head_idx;
          cur_mode = MODE_NODE;
          r.value  = node_val[head_idx];
        end
      end
      CMD_NEXT, CMD_PREV: begin
        if (cmd == CMD_NEXT && cur_mode == MODE_BEFORE) n = head_idx;
        else if (cur_mode == MODE_NODE && cur_idx != NIL)
          n = (cmd == CMD_NEXT) ? fwd_link[cur_idx] : back_link[cur_idx];
        if (n == NIL) begin
          r.status = STAT_END;
        end else begin
          cur_idx  = n;
          cur_mode = MODE_NODE;
          r.value  = node_val[n];
        end
      end
      CMD_REMOVE: begin
        if (cur_mode != MODE_NODE || cur_idx == NIL) begin
          r.status = STAT_NOCUR;
        end else begin
          n       = cur_idx;
          r.value = node_val[n];
          p       = back_link[n];
          q       = fwd_link[n];
          if (p != NIL) fwd_link[p] = q;
          else head_idx = q;
          if (q != NIL) back_link[q] = p;
          else tail_idx = p;
          fwd_link[n] = free_idx;
          free_idx    = n;
          cur_idx     = p;
          cur_mode    = (p != NIL) ? MODE_NODE : MODE_BEFORE;
          if (elem_count != 0) elem_count = elem_count - 1'b1;
        end
      end
      default: ;  // unused codes leave everything as is
    endcase
    r.count = elem_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      head_idx   = NIL;
      tail_idx   = NIL;
      cur_idx    = NIL;
      free_idx   = NIL;
      fresh_idx  = '0;
      elem_count = '0;
      cur_mode   = MODE_NONE;
      result_q.delete();
      outstanding_o <= 0;
      fail_count_o  <= errors;
    end else begin
      // retire first: a new command transfer in the strobe cycle is younger
      if (done_o) begin
        if (result_q.size() == 0) begin
          $error("result transfer with no command outstanding");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
            errors++;
          end
          if (value_out_o !== want.value) begin
            $error("value_out mismatch: expected %0d, actual %0d", want.value, value_out_o);
            errors++;
          end
          if (element_count_o !== want.count) begin
            $error("element_count mismatch: expected %0d, actual %0d",
                   want.count, element_count_o);
            errors++;
          end
        end
      end
      if (start && !busy) result_q.push_back(apply_command(command_i, value_i));
      outstanding_o <= result_q.size();
      fail_count_o  <= errors;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Stimulus and verdict for the list engine. All prediction and comparison
// lives in dllc_checker, which sits beside the block and hands back a failure
// count and the number of results still outstanding.
module tb_top;
  import dllc_pkg::*;

  localparam int POOL_DEPTH = 256;
  localparam int DATA_WIDTH = 32;
  localparam int CW         = $clog2(POOL_DEPTH + 1);
  // The longest stretch of a correct run without a transfer is one sender gap
  // plus one command, so this limit is many times over.
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 10;

  typedef enum int {PH_MIXED, PH_FILL, PH_DRAIN, PH_NOISE} phase_e;

  logic                         clk_i;
  logic                         rst_ni    = 1'b0;
  logic                         start     = 1'b0;
  logic                         busy;
  logic [2:0]                   command_i = CMD_APPEND;
  logic signed [DATA_WIDTH-1:0] value_i   = '0;
  logic                         done_o;
  logic [1:0]                   status_o;
  logic signed [DATA_WIDTH-1:0] value_out_o;
  logic [CW-1:0]                element_count_o;
  int                           fail_count;
  int                           pending;

  int calm_left = 0;   // items left in a stretch with no gaps
  int idle_cycles = 0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  doubly_linked_list_cursor_engine #(
    .POOL_DEPTH(POOL_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .value_out_o    (value_out_o),
    .element_count_o(element_count_o)
  );

  dllc_checker #(
    .POOL_DEPTH(POOL_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .value_out_o    (value_out_o),
    .element_count_o(element_count_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (pending)
  );

  // Watchdog: any command or result transfer resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one command at the falling edge and hold it until the rising
  // edge that takes it. start stays high if the next command follows at once,
  // so it is never lowered and raised in the same step.
  task automatic send_command(input logic [2:0] cmd, input logic signed [DATA_WIDTH-1:0] val);
    @(negedge clk_i);
    start     <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    do @(posedge clk_i); while (busy);
  endtask

  // Sender gap after a transfer, of random length, with occasional gap-free runs.
  task automatic pace();
    int gap;
    if (calm_left == 0 && $urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 6);
    end
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic issue(input logic [2:0] cmd, input logic signed [DATA_WIDTH-1:0] val);
    send_command(cmd, val);
    pace();
  endtask

  // Hold the sender off until every result has come back.
  task automatic hold_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  // Command mix per phase; the weights steer the list length up or down so
  // the pool fills (full case) and later empties again.
  function automatic logic [2:0] pick_command(phase_e ph);
    int roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_MIXED: begin
        if (roll < 30) return CMD_APPEND;
        if (roll < 40) return CMD_FIRST;
        if (roll < 65) return CMD_NEXT;
        if (roll < 80) return CMD_PREV;
        return CMD_REMOVE;
      end
      PH_FILL: begin
        if (roll < 75) return CMD_APPEND;
        if (roll < 80) return CMD_FIRST;
        if (roll < 90) return CMD_NEXT;
        if (roll < 95) return CMD_PREV;
        return CMD_REMOVE;
      end
      PH_DRAIN: begin
        if (roll < 5)  return CMD_APPEND;
        if (roll < 10) return CMD_FIRST;
        if (roll < 48) return CMD_NEXT;
        if (roll < 52) return CMD_PREV;
        return CMD_REMOVE;
      end
      default: return 3'($urandom_range(0, 7));  // unused codes included
    endcase
  endfunction

  task automatic run_phase(input phase_e ph, input int items);
    repeat (items) issue(pick_command(ph), pick_value());
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: failures on an empty list with no cursor, unused codes,
    // data extremes, moves at both ends, removal of the first node into the
    // before-first position, and go next from there on a non-empty and an empty list.
    issue(CMD_FIRST, '0);
    issue(CMD_NEXT, '0);
    issue(CMD_PREV, '0);
    issue(CMD_REMOVE, '0);
    issue(3'd5, '1);
    issue(3'd6, DATA_WIDTH'($urandom));
    issue(3'd7, '0);
    issue(CMD_APPEND, {1'b1, {(DATA_WIDTH-1){1'b0}}});
    issue(CMD_APPEND, {1'b0, {(DATA_WIDTH-1){1'b1}}});
    issue(CMD_APPEND, '0);
    issue(CMD_APPEND, '1);
    issue(CMD_FIRST, '0);
    issue(CMD_PREV, '0);     // at first node
    issue(CMD_REMOVE, '0);   // first node, cursor goes before first
    issue(CMD_PREV, '0);     // before first
    issue(CMD_REMOVE, '0);   // before first
    issue(CMD_NEXT, '0);     // before first -> first node
    issue(CMD_NEXT, '0);
    issue(CMD_NEXT, '0);
    issue(CMD_NEXT, '0);     // at last node
    issue(CMD_REMOVE, '0);   // last node
    issue(CMD_REMOVE, '0);
    issue(CMD_REMOVE, '0);   // list now empty, cursor before first
    issue(CMD_NEXT, '0);     // before first on an empty list
    issue(CMD_APPEND, DATA_WIDTH'($urandom));
    hold_until_drained();

    run_phase(PH_MIXED, 250);
    hold_until_drained();
    run_phase(PH_FILL, 400);
    hold_until_drained();
    run_phase(PH_DRAIN, 550);
    hold_until_drained();
    run_phase(PH_NOISE, 150);

    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
